>>> rtl/core/pku_pkg.sv
// Package for the pose Kalman update block: fixed-point constants, the
// CORDIC arctangent table, the sequencer control word types and its program.
// No dependencies.
`default_nettype none

package pku_pkg;

    // CORDIC step count, at most the table length below
    localparam int CORDIC_ITERS = 16;
    localparam int ATAN_LEN     = 24;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_MOTION_VAR  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_MEASURE_VAR = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_START_VAR   = CFG_ADDR_W'(2);

    localparam logic [31:0] MOTION_VAR_RST  = 32'd32768;
    localparam logic [31:0] MEASURE_VAR_RST = 32'd655360;
    localparam logic [31:0] START_VAR_RST   = 32'd65536000;

    // angles
    localparam logic signed [17:0] TWO_PI_Q13      = 18'sd51472;
    localparam logic signed [19:0] PI_Q13          = 20'sd25736;
    localparam logic signed [33:0] PI_Q28          = 34'sd843314857;
    localparam logic signed [33:0] TWO_PI_Q28      = 34'sd1686629714;
    localparam logic signed [33:0] HALF_PI_Q28     = 34'sd421657428;
    localparam logic signed [43:0] CORDIC_GAIN_Q30 = 44'sd652032874;

    // step vector normalisation bounds
    localparam logic [43:0] NORM_LIMIT  = 44'd1 << 40;
    localparam logic [43:0] COARSE_LIMIT = 44'd1 << 32;

    // datapath operations, one per control word
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_NOP,
        OP_MUL_RATE,
        OP_ANGLE,
        OP_WRAP,
        OP_ROT_INIT,
        OP_CORDIC,
        OP_MUL_COS,
        OP_MUL_DIST,
        OP_POS_X,
        OP_POS_Y,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_GAIN,
        OP_MUL_BX,
        OP_BLEND_X,
        OP_BLEND_Y,
        OP_MUL_VAR,
        OP_VAR,
        OP_VEC_LOAD,
        OP_NORM,
        OP_VEC_INIT,
        OP_HEAD,
        OP_COMMIT,
        OP_ZERO_HEAD
    } t_op;

    // jump conditions: when true go to the target, else to the next step
    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_INPUT,
        C_ANG_OUT,
        C_CORDIC_BUSY,
        C_DIV_BUSY,
        C_MAG_ZERO,
        C_MAG_LOW,
        C_OUT_BUSY
    } t_cond;

    localparam int PC_W = 5;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uop;

    // program addresses that are jumped to
    localparam logic [PC_W-1:0] P_IDLE      = PC_W'(0);
    localparam logic [PC_W-1:0] P_WRAP      = PC_W'(3);
    localparam logic [PC_W-1:0] P_ROT       = PC_W'(5);
    localparam logic [PC_W-1:0] P_DIV       = PC_W'(12);
    localparam logic [PC_W-1:0] P_NORM      = PC_W'(21);
    localparam logic [PC_W-1:0] P_VEC       = PC_W'(23);
    localparam logic [PC_W-1:0] P_COMMIT    = PC_W'(25);
    localparam logic [PC_W-1:0] P_ZERO_HEAD = PC_W'(27);

    // control store
    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        unique case (pc)
            5'd0:  u = '{OP_IDLE,      C_NO_INPUT,    P_IDLE};
            5'd1:  u = '{OP_MUL_RATE,  C_NEXT,        P_IDLE};
            5'd2:  u = '{OP_ANGLE,     C_NEXT,        P_IDLE};
            5'd3:  u = '{OP_WRAP,      C_ANG_OUT,     P_WRAP};
            5'd4:  u = '{OP_ROT_INIT,  C_NEXT,        P_IDLE};
            5'd5:  u = '{OP_CORDIC,    C_CORDIC_BUSY, P_ROT};
            5'd6:  u = '{OP_MUL_COS,   C_NEXT,        P_IDLE};
            5'd7:  u = '{OP_MUL_DIST,  C_NEXT,        P_IDLE};
            5'd8:  u = '{OP_POS_X,     C_NEXT,        P_IDLE};
            5'd9:  u = '{OP_MUL_DIST,  C_NEXT,        P_IDLE};
            5'd10: u = '{OP_POS_Y,     C_NEXT,        P_IDLE};
            5'd11: u = '{OP_DIV_INIT,  C_NEXT,        P_IDLE};
            5'd12: u = '{OP_DIV_STEP,  C_DIV_BUSY,    P_DIV};
            5'd13: u = '{OP_GAIN,      C_NEXT,        P_IDLE};
            5'd14: u = '{OP_MUL_BX,    C_NEXT,        P_IDLE};
            5'd15: u = '{OP_BLEND_X,   C_NEXT,        P_IDLE};
            5'd16: u = '{OP_BLEND_Y,   C_NEXT,        P_IDLE};
            5'd17: u = '{OP_MUL_VAR,   C_NEXT,        P_IDLE};
            5'd18: u = '{OP_VAR,       C_NEXT,        P_IDLE};
            5'd19: u = '{OP_VEC_LOAD,  C_NEXT,        P_IDLE};
            5'd20: u = '{OP_NOP,       C_MAG_ZERO,    P_ZERO_HEAD};
            5'd21: u = '{OP_NORM,      C_MAG_LOW,     P_NORM};
            5'd22: u = '{OP_VEC_INIT,  C_NEXT,        P_IDLE};
            5'd23: u = '{OP_CORDIC,    C_CORDIC_BUSY, P_VEC};
            5'd24: u = '{OP_HEAD,      C_NEXT,        P_IDLE};
            5'd25: u = '{OP_COMMIT,    C_OUT_BUSY,    P_COMMIT};
            5'd26: u = '{OP_NOP,       C_ALWAYS,      P_IDLE};
            5'd27: u = '{OP_ZERO_HEAD, C_ALWAYS,      P_COMMIT};
            default: u = '{OP_NOP,     C_ALWAYS,      P_IDLE};
        endcase
        return u;
    endfunction

    // arctangent of 2^-i in Q.28
    function automatic logic signed [33:0] atan_q28(input logic [4:0] i);
        logic signed [33:0] a;
        unique case (i)
            5'd0:  a = 34'sd210828714;
            5'd1:  a = 34'sd124459457;
            5'd2:  a = 34'sd65760959;
            5'd3:  a = 34'sd33381290;
            5'd4:  a = 34'sd16755422;
            5'd5:  a = 34'sd8385879;
            5'd6:  a = 34'sd4193963;
            5'd7:  a = 34'sd2097109;
            5'd8:  a = 34'sd1048571;
            5'd9:  a = 34'sd524287;
            5'd10: a = 34'sd262144;
            5'd11: a = 34'sd131072;
            5'd12: a = 34'sd65536;
            5'd13: a = 34'sd32768;
            5'd14: a = 34'sd16384;
            5'd15: a = 34'sd8192;
            5'd16: a = 34'sd4096;
            5'd17: a = 34'sd2048;
            5'd18: a = 34'sd1024;
            5'd19: a = 34'sd512;
            5'd20: a = 34'sd256;
            5'd21: a = 34'sd128;
            5'd22: a = 34'sd64;
            5'd23: a = 34'sd32;
            default: a = 34'sd0;
        endcase
        return a;
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        logic signed [31:0] r;
        if (v > 38'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -38'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/pose_kalman_update.sv
// Pose Kalman update: microcoded sequencer over one shared multiplier,
// a shared CORDIC stage and a bit-serial divider. Depends on pku_pkg.
//
// Use: one input beat on the s_axis side carries speed, turn rate, time
// step and a measured x,y; one result beat on the m_axis side returns the
// filtered x, y and the heading of the step. Noise variances are written
// on the cfg channel (index 0 motion, 1 measurement, 2 start variance),
// which is always ready; index 2 is taken but the variance after reset is
// always the default start value, so a written start value has no effect.
// The result beat follows the input beat after two CORDIC passes (sin/cos,
// then atan2), a gain divider, the angle wrap steps and the normalisation
// steps, all on one datapath stepped by the program; a zero step skips the
// second pass. The input is ready again when the program returns to its
// idle step after the commit step and a no-op step, so a new item is taken
// only once the last one is through.
// The result sits in an output register; if the receiver stalls, the next
// item runs up to its final step and waits there until the register frees.
// Reset (synchronous, active low) clears the pose to zero, reloads the
// variance and the registers with their defaults and drops any result.
`default_nettype none

module pose_kalman_update (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input beats
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [15:0] speed, [31:16] turn_rate, [47:32] step_time,
    // [79:48] meas_x, [111:80] meas_y
    input  wire logic [111:0]                  i_s_axis_tdata,
    // result beats
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // [31:0] est_x, [63:32] est_y, [79:64] est_heading
    output logic [79:0]                        o_m_axis_tdata,
    // register writes
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [pku_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [31:0]                   i_cfg_data
);
    import pku_pkg::*;

    // sequencer
    logic [PC_W-1:0] r_pc, n_pc;
    t_uop            uop;

    // configuration
    logic [31:0] r_motion_var, r_measure_var;

    // filter state
    logic signed [31:0] r_pose_x, r_pose_y;
    logic signed [15:0] r_pose_head;
    logic [31:0]        r_variance;

    // captured input
    logic signed [15:0] r_speed, r_rate;
    logic [15:0]        r_dt;
    logic signed [31:0] r_mx, r_my;

    // working registers
    logic signed [67:0] r_prod;
    logic signed [17:0] r_ang;
    logic signed [43:0] r_cx, r_cy;
    logic signed [33:0] r_cz;
    logic               r_neg, r_vec_mode;
    logic [4:0]         r_cnt;
    logic signed [33:0] r_px, r_py;
    logic [32:0]        r_sum, r_rem;
    logic [16:0]        r_q, r_k;
    logic signed [31:0] r_nx, r_ny;
    logic signed [15:0] r_head;

    // output register
    logic        r_out_valid;
    logic [79:0] r_out_data;

    // combinational helpers
    logic               in_fire, out_busy, commit_fire, cfg_fire;
    logic               ang_out, cordic_last, div_last, mag_zero, mag_low, cond_true;
    logic               mul_en;
    logic signed [49:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [43:0] cos_v, sin_v, sh_x, sh_y, abs_x, abs_y;
    logic [43:0]        mag;
    logic               cd_dir;
    logic signed [33:0] atan_v;
    logic signed [33:0] dang_t;
    logic signed [18:0] ang_sum;
    logic signed [33:0] z0, z1;
    logic signed [67:0] trav_t;
    logic signed [29:0] trav;
    logic signed [33:0] pos_new;
    logic [32:0]        sum_now;
    logic [48:0]        div_n;
    logic [33:0]        div_t;
    logic               div_ge;
    logic signed [33:0] bdiff_x, bdiff_y;
    logic signed [67:0] blend_t;
    logic signed [31:0] blend_v;
    logic [49:0]        var_t;
    logic [34:0]        var_sum;
    logic signed [34:0] head_t;
    logic signed [19:0] head_r, head_c, head_abs;
    logic signed [32:0] step_x, step_y;

    assign uop = uop_rom(r_pc);

    // handshakes
    assign o_s_axis_tready = (uop.op == OP_IDLE);
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_busy        = r_out_valid && !i_m_axis_tready;
    assign commit_fire     = (uop.op == OP_COMMIT) && !out_busy;
    assign o_cfg_ready     = 1'b1;
    assign cfg_fire        = i_cfg_valid && o_cfg_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // status seen by the jump conditions
    assign ang_out     = (r_ang > TWO_PI_Q13) || (r_ang < 18'sd0);
    assign cordic_last = (r_cnt == 5'(CORDIC_ITERS - 1));
    assign div_last    = (r_cnt == 5'd16);
    assign abs_x       = r_cx[43] ? -r_cx : r_cx;
    assign abs_y       = r_cy[43] ? -r_cy : r_cy;
    assign mag         = (abs_x > abs_y) ? abs_x : abs_y;
    assign mag_zero    = (mag == 44'd0);
    assign mag_low     = (mag < NORM_LIMIT);

    always_comb begin
        unique case (uop.cond)
            C_NEXT:        cond_true = 1'b0;
            C_ALWAYS:      cond_true = 1'b1;
            C_NO_INPUT:    cond_true = !i_s_axis_tvalid;
            C_ANG_OUT:     cond_true = ang_out;
            C_CORDIC_BUSY: cond_true = !cordic_last;
            C_DIV_BUSY:    cond_true = !div_last;
            C_MAG_ZERO:    cond_true = mag_zero;
            C_MAG_LOW:     cond_true = mag_low;
            C_OUT_BUSY:    cond_true = out_busy;
            default:       cond_true = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        if (cond_true) begin
            n_pc = uop.target;
        end else begin
            n_pc = r_pc + PC_W'(1);
        end
    end

    // shared multiplier operand selection
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (uop.op)
            OP_MUL_RATE: begin
                mul_a = 50'(r_rate);
                mul_b = $signed({2'b00, r_dt});
            end
            OP_MUL_COS: begin
                mul_a = 50'(cos_v);
                mul_b = $signed({2'b00, r_dt});
            end
            OP_POS_X: begin
                mul_a = 50'(sin_v);
                mul_b = $signed({2'b00, r_dt});
            end
            OP_MUL_DIST: begin
                mul_a = r_prod[49:0];
                mul_b = 18'(r_speed);
            end
            OP_MUL_BX: begin
                mul_a = 50'(bdiff_x);
                mul_b = $signed({1'b0, r_k});
            end
            OP_BLEND_X: begin
                mul_a = 50'(bdiff_y);
                mul_b = $signed({1'b0, r_k});
            end
            OP_MUL_VAR: begin
                mul_a = $signed({18'd0, r_variance});
                mul_b = $signed({1'b0, 17'd65536 - r_k});
            end
            default: mul_en = 1'b0;
        endcase
    end

    // prediction angle and rotation start
    assign dang_t  = r_prod[33:0] + 34'sd16384;
    assign ang_sum = dang_t[33:15] + 19'(r_pose_head);
    assign z0      = 34'(r_ang) <<< 15;
    assign z1      = (z0 > PI_Q28) ? z0 - TWO_PI_Q28 : z0;

    // CORDIC stage, rotation or vectoring
    assign sh_x   = r_cx >>> r_cnt;
    assign sh_y   = r_cy >>> r_cnt;
    assign atan_v = atan_q28(r_cnt);
    assign cd_dir = r_vec_mode ? r_cy[43] : !r_cz[33];
    assign cos_v  = r_neg ? -r_cx : r_cx;
    assign sin_v  = r_neg ? -r_cy : r_cy;

    // travel along the heading
    assign trav_t  = r_prod + (68'sd1 <<< 37);
    assign trav    = trav_t[67:38];
    assign pos_new = ((uop.op == OP_POS_X) ? 34'(r_pose_x) : 34'(r_pose_y)) + 34'(trav);

    // gain divider
    assign sum_now = {1'b0, r_variance} + {1'b0, r_measure_var};
    assign div_n   = {1'b0, r_variance, 16'd0} + 49'(sum_now >> 1);
    assign div_t   = {r_rem, r_q[16]};
    assign div_ge  = (div_t >= {1'b0, r_sum});

    // blend toward the measurement
    assign bdiff_x = 34'(r_mx) - r_px;
    assign bdiff_y = 34'(r_my) - r_py;
    assign blend_t = r_prod + 68'sd32768;
    assign blend_v = sat32(38'((uop.op == OP_BLEND_X) ? r_px : r_py)
                           + 38'($signed(blend_t[51:16])));

    // variance update
    assign var_t   = {1'b0, r_prod[48:0]} + 50'd32768;
    assign var_sum = {1'b0, var_t[49:16]} + {3'd0, r_motion_var};

    // heading from the vectoring angle
    assign head_t   = 35'(r_cz) + 35'sd16384;
    assign head_r   = head_t[34:15];
    assign head_c   = (head_r > PI_Q13) ? PI_Q13 : ((head_r < -PI_Q13) ? -PI_Q13 : head_r);
    assign head_abs = head_c[19] ? -head_c : head_c;

    // step from the old pose
    assign step_x = 33'(r_nx) - 33'(r_pose_x);
    assign step_y = 33'(r_ny) - 33'(r_pose_y);

    // control, configuration and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc          <= P_IDLE;
            r_out_valid   <= 1'b0;
            r_motion_var  <= MOTION_VAR_RST;
            r_measure_var <= MEASURE_VAR_RST;
            r_variance    <= START_VAR_RST;
            r_pose_x      <= '0;
            r_pose_y      <= '0;
            r_pose_head   <= '0;
        end else begin
            r_pc <= n_pc;
            if (commit_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_fire) begin
                // start variance writes are taken and have no effect
                if (i_cfg_addr == REG_MOTION_VAR) begin
                    r_motion_var <= i_cfg_data;
                end else if (i_cfg_addr == REG_MEASURE_VAR) begin
                    r_measure_var <= i_cfg_data;
                end
            end
            if (uop.op == OP_VAR) begin
                r_variance <= var_sum[34:32] != 3'd0 ? 32'hFFFFFFFF : var_sum[31:0];
            end
            if (commit_fire) begin
                r_pose_x    <= r_nx;
                r_pose_y    <= r_ny;
                r_pose_head <= r_head;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (commit_fire) begin
            r_out_data <= {r_head, r_ny, r_nx};
        end
    end

    // multiplier product
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_speed <= $signed(i_s_axis_tdata[15:0]);
            r_rate  <= $signed(i_s_axis_tdata[31:16]);
            r_dt    <= i_s_axis_tdata[47:32];
            r_mx    <= $signed(i_s_axis_tdata[79:48]);
            r_my    <= $signed(i_s_axis_tdata[111:80]);
        end
        unique case (uop.op)
            OP_ANGLE: r_ang <= 18'(ang_sum);
            OP_WRAP: begin
                if (r_ang > TWO_PI_Q13) begin
                    r_ang <= r_ang - TWO_PI_Q13;
                end else if (r_ang < 18'sd0) begin
                    r_ang <= r_ang + TWO_PI_Q13;
                end
            end
            OP_ROT_INIT: begin
                // fold into the right half plane, flip the result back after
                r_cx       <= CORDIC_GAIN_Q30;
                r_cy       <= '0;
                r_cnt      <= '0;
                r_vec_mode <= 1'b0;
                if (z1 > HALF_PI_Q28) begin
                    r_cz  <= z1 - PI_Q28;
                    r_neg <= 1'b1;
                end else if (z1 < -HALF_PI_Q28) begin
                    r_cz  <= z1 + PI_Q28;
                    r_neg <= 1'b1;
                end else begin
                    r_cz  <= z1;
                    r_neg <= 1'b0;
                end
            end
            OP_CORDIC: begin
                r_cnt <= r_cnt + 5'd1;
                if (cd_dir) begin
                    r_cx <= r_cx - sh_y;
                    r_cy <= r_cy + sh_x;
                    r_cz <= r_cz - atan_v;
                end else begin
                    r_cx <= r_cx + sh_y;
                    r_cy <= r_cy - sh_x;
                    r_cz <= r_cz + atan_v;
                end
            end
            OP_POS_X: r_px <= pos_new;
            OP_POS_Y: r_py <= pos_new;
            OP_DIV_INIT: begin
                r_sum <= sum_now;
                r_rem <= {1'b0, div_n[48:17]};
                r_q   <= div_n[16:0];
                r_cnt <= '0;
            end
            OP_DIV_STEP: begin
                r_cnt <= r_cnt + 5'd1;
                r_rem <= div_ge ? 33'(div_t - {1'b0, r_sum}) : div_t[32:0];
                r_q   <= {r_q[15:0], div_ge};
            end
            OP_GAIN: begin
                // no noise at all keeps the prediction
                if (r_sum == 33'd0) begin
                    r_k <= '0;
                end else begin
                    r_k <= (r_q > 17'd65536) ? 17'd65536 : r_q;
                end
            end
            OP_BLEND_X: r_nx <= blend_v;
            OP_BLEND_Y: r_ny <= blend_v;
            OP_VEC_LOAD: begin
                r_cx <= 44'(step_x);
                r_cy <= 44'(step_y);
                r_cz <= '0;
            end
            OP_NORM: begin
                if (mag_low) begin
                    if (mag < COARSE_LIMIT) begin
                        r_cx <= r_cx <<< 8;
                        r_cy <= r_cy <<< 8;
                    end else begin
                        r_cx <= r_cx <<< 1;
                        r_cy <= r_cy <<< 1;
                    end
                end
            end
            OP_VEC_INIT: begin
                // left half plane starts from plus or minus pi
                r_cnt      <= '0;
                r_vec_mode <= 1'b1;
                if (r_cx[43]) begin
                    r_cz <= r_cy[43] ? -PI_Q28 : PI_Q28;
                    r_cx <= -r_cx;
                    r_cy <= -r_cy;
                end else begin
                    r_cz <= '0;
                end
            end
            OP_HEAD: r_head <= r_speed[15] ? -16'(head_abs) : 16'(head_abs);
            OP_ZERO_HEAD: r_head <= '0;
            default: ;
        endcase
    end

    // checks
    a_ang_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uop.op == OP_ROT_INIT) |-> (r_ang >= 18'sd0 && r_ang <= TWO_PI_Q13))
        else $error("prediction angle not wrapped before rotation");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uop.op == OP_DIV_STEP && r_sum != 33'd0) |-> (r_rem < r_sum))
        else $error("divider remainder not below divisor");

    a_gain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uop.op == OP_MUL_BX) |-> (r_k <= 17'd65536))
        else $error("gain above one");

    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit_fire |=> (r_out_valid && $signed(r_out_data[31:0]) == r_pose_x
                         && $signed(r_out_data[79:64]) == r_pose_head))
        else $error("result beat does not match committed pose");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pose_head <= 16'sd25736 && r_pose_head >= -16'sd25736))
        else $error("held heading out of range");

endmodule

`default_nettype wire
